// File: design/udiv_256_by_128_defines.svh
// ----------------------------------------------------------------------------
// udiv_256_by_128 assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef UDIV_256_BY_128_DEFINES_SVH
`define UDIV_256_BY_128_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define UDIV_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define UDIV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define UDIV_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define UDIV_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// File: design/udiv_pkg.sv
// ----------------------------------------------------------------------------
// udiv_pkg
// Widths and pipeline types shared by the 256/128 divider.
// ----------------------------------------------------------------------------
package udiv_pkg;

   localparam int unsigned WORD_W    = 64;
   localparam int unsigned NUM_W     = 4 * WORD_W;
   localparam int unsigned DEN_W     = 2 * WORD_W;
   localparam int unsigned NUM_STEPS = NUM_W;

   // Per-stage payload. nq holds the numerator bits still to be consumed in
   // its upper part and the quotient bits produced so far in its lower part.
   typedef struct packed {
      logic             dz;
      logic [NUM_W-1:0] nq;
      logic [DEN_W-1:0] rem;
      logic [DEN_W-1:0] den;
   } stage_type;

   typedef struct packed {
      logic             dz;
      logic [NUM_W-1:0] quo;
      logic [DEN_W-1:0] rem;
   } result_type;

endpackage

// File: design/udiv_if.sv
// ----------------------------------------------------------------------------
// udiv channel interfaces
// Valid/ready request and response channels of the 256/128 divider.
// ----------------------------------------------------------------------------
interface udiv_req_if;
   import udiv_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] numerator_w0;
   logic [WORD_W-1:0] numerator_w1;
   logic [WORD_W-1:0] numerator_w2;
   logic [WORD_W-1:0] numerator_w3;
   logic [WORD_W-1:0] denominator_lo;
   logic [WORD_W-1:0] denominator_hi;

   modport source (
      output valid, numerator_w0, numerator_w1, numerator_w2, numerator_w3,
             denominator_lo, denominator_hi,
      input  ready
   );
   modport sink (
      input  valid, numerator_w0, numerator_w1, numerator_w2, numerator_w3,
             denominator_lo, denominator_hi,
      output ready
   );
endinterface

interface udiv_rsp_if;
   import udiv_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] quotient_w0;
   logic [WORD_W-1:0] quotient_w1;
   logic [WORD_W-1:0] quotient_w2;
   logic [WORD_W-1:0] quotient_w3;
   logic [WORD_W-1:0] remainder_lo;
   logic [WORD_W-1:0] remainder_hi;
   logic              divide_by_zero;

   modport source (
      output valid, quotient_w0, quotient_w1, quotient_w2, quotient_w3,
             remainder_lo, remainder_hi, divide_by_zero,
      input  ready
   );
   modport sink (
      input  valid, quotient_w0, quotient_w1, quotient_w2, quotient_w3,
             remainder_lo, remainder_hi, divide_by_zero,
      output ready
   );
endinterface

// File: design/udiv_256_by_128.sv
// ----------------------------------------------------------------------------
// udiv_256_by_128 - 256-bit by 128-bit unsigned divider
// Structure: one pipeline stage per quotient bit, then an output register.
// Throughput: one division per cycle while the skid entry is empty; a
//   two-entry output buffer keeps the pipeline moving when the response
//   side first stalls, and the pipeline halts once its skid entry is full.
// Reset (synchronous, active high) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
`include "udiv_256_by_128_defines.svh"
module udiv_256_by_128 (
   input  logic          clock,
   input  logic          reset,
   udiv_req_if.sink      req_if,
   udiv_rsp_if.source    rsp_if
);
   import udiv_pkg::*;

   logic       pipe_en;
   logic       stage_valid [NUM_STEPS];
   stage_type  stage_state [NUM_STEPS];
   stage_type  entry_state;
   logic       pipe_valid;
   result_type pipe_res;
   logic       out_free;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff,  rsp_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff,  skid_data_in;

   // whole pipeline advances together; it only halts when the skid is full
   assign pipe_en       = ~skid_valid_ff;
   assign req_if.ready  = pipe_en;

   always_comb begin
      entry_state.nq  = {req_if.numerator_w3, req_if.numerator_w2,
                         req_if.numerator_w1, req_if.numerator_w0};
      entry_state.den = {req_if.denominator_hi, req_if.denominator_lo};
      entry_state.rem = '0;
      entry_state.dz  = (entry_state.den == '0);
   end

   for (genvar g = 0; g < NUM_STEPS; g++) begin : g_step
      if (g == 0) begin : g_first
         udiv_stage u_stage (
            .clock      (clock),
            .reset      (reset),
            .enable     (pipe_en),
            .prev_valid (req_if.valid),
            .prev_state (entry_state),
            .next_valid (stage_valid[g]),
            .next_state (stage_state[g])
         );
      end else begin : g_rest
         udiv_stage u_stage (
            .clock      (clock),
            .reset      (reset),
            .enable     (pipe_en),
            .prev_valid (stage_valid[g-1]),
            .prev_state (stage_state[g-1]),
            .next_valid (stage_valid[g]),
            .next_state (stage_state[g])
         );
      end
   end

   always_comb begin
      pipe_valid   = stage_valid[NUM_STEPS-1];
      pipe_res.dz  = stage_state[NUM_STEPS-1].dz;
      pipe_res.quo = pipe_res.dz ? '0 : stage_state[NUM_STEPS-1].nq;
      pipe_res.rem = pipe_res.dz ? '0 : stage_state[NUM_STEPS-1].rem;
   end

   assign out_free = ~rsp_valid_ff | rsp_if.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in  = pipe_valid;
            rsp_data_in   = pipe_res;
         end
      end else if (pipe_en && pipe_valid) begin
         // response stalled: park the transaction leaving the pipeline
         skid_valid_in = 1'b1;
         skid_data_in  = pipe_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.quotient_w0    = rsp_data_ff.quo[WORD_W-1:0];
   assign rsp_if.quotient_w1    = rsp_data_ff.quo[2*WORD_W-1:WORD_W];
   assign rsp_if.quotient_w2    = rsp_data_ff.quo[3*WORD_W-1:2*WORD_W];
   assign rsp_if.quotient_w3    = rsp_data_ff.quo[4*WORD_W-1:3*WORD_W];
   assign rsp_if.remainder_lo   = rsp_data_ff.rem[WORD_W-1:0];
   assign rsp_if.remainder_hi   = rsp_data_ff.rem[2*WORD_W-1:WORD_W];
   assign rsp_if.divide_by_zero = rsp_data_ff.dz;

   `UDIV_ASSERT_IMPL(a_skid_only_behind_output, clock, reset,
      skid_valid_ff, rsp_valid_ff, "skid holds data while output is empty")
   `UDIV_ASSERT_NEXT(a_last_stage_holds, clock, reset, !pipe_en,
      $stable(stage_valid[NUM_STEPS-1]) && $stable(stage_state[NUM_STEPS-1]),
      "last pipeline stage changed while halted")
   `UDIV_ASSERT_IMPL(a_dz_zero_result, clock, reset,
      rsp_valid_ff && rsp_data_ff.dz,
      (rsp_data_ff.quo == '0) && (rsp_data_ff.rem == '0),
      "divide by zero response carries non-zero data")

endmodule

// File: design/udiv_stage.sv
// ----------------------------------------------------------------------------
// udiv_stage
// One registered restoring-division step: shift in a numerator bit, trial
// subtract the denominator, keep the difference when it does not borrow.
// ----------------------------------------------------------------------------
module udiv_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                prev_valid,
   input  udiv_pkg::stage_type prev_state,
   output logic                next_valid,
   output udiv_pkg::stage_type next_state
);
   import udiv_pkg::*;

   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] diff;
   logic             qbit;
   logic             valid_ff;
   stage_type        state_in;
   stage_type        state_ff;

   always_comb begin
      // top bit of shifted is the carry out of the doubled remainder
      shifted  = {prev_state.rem, prev_state.nq[NUM_W-1]};
      diff     = {1'b0, shifted} - {2'b00, prev_state.den};
      qbit     = ~diff[DEN_W+1];
      state_in = prev_state;
      state_in.nq  = {prev_state.nq[NUM_W-2:0], qbit};
      state_in.rem = qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         state_ff <= state_in;
      end
   end

   assign next_valid = valid_ff;
   assign next_state = state_ff;

endmodule

// File: bench/udiv_256_by_128_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// udiv_256_by_128_tb - testbench for the 256/128 unsigned divider
// Drives division requests with random gaps and response back-pressure,
// predicts quotient, remainder and divide-by-zero with a bit-serial restoring
// division, and checks every response transaction in order.
// ----------------------------------------------------------------------------
module udiv_256_by_128_tb;
   import udiv_pkg::*;

   localparam int unsigned CLK_HALF    = 5;
   localparam int unsigned RESET_TICKS = 9;
   localparam int unsigned LATENCY     = 256;
   localparam int unsigned SETTLE      = LATENCY + 50;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned LONG_HOLD   = 700;
   localparam int unsigned MAX_GAP     = 6;

   localparam logic [NUM_W-1:0]  NUM_MAX  = {NUM_W{1'b1}};
   localparam logic [DEN_W-1:0]  DEN_MAX  = {DEN_W{1'b1}};
   localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};
   localparam logic [WORD_W-1:0] WORD_MSB = {1'b1, {(WORD_W-1){1'b0}}};

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } division_type;

   // ---------------------------------------------------------------------
   // Scoreboard: holds predicted results in order of acceptance
   // ---------------------------------------------------------------------
   class division_scoreboard;
      result_type expected_q[$];
      int         errors;

      function new();
         errors = 0;
      endfunction

      // restoring division over all numerator bits; the 129-bit partial
      // remainder keeps the bit shifted out of the doubled remainder
      function result_type divide_restoring(logic [NUM_W-1:0] num,
                                            logic [DEN_W-1:0] den);
         result_type       res;
         logic [DEN_W:0]   partial;
         res     = '0;
         partial = '0;
         if (den == '0) begin
            res.dz = 1'b1;
            return res;
         end
         for (int i = NUM_W - 1; i >= 0; i--) begin
            partial = {partial[DEN_W-1:0], num[i]};
            if (partial >= {1'b0, den}) begin
               partial    = partial - {1'b0, den};
               res.quo[i] = 1'b1;
            end
         end
         res.rem = partial[DEN_W-1:0];
         return res;
      endfunction

      function void note_division(logic [NUM_W-1:0] num, logic [DEN_W-1:0] den);
         expected_q.push_back(divide_restoring(num, den));
      endfunction

      function void compare_field(string name, logic [WORD_W-1:0] exp_val,
                                  logic [WORD_W-1:0] act_val);
         if (exp_val !== act_val) begin
            errors++;
            $display("%0t %s mismatch: expected %h, actual %h",
                     $time, name, exp_val, act_val);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t unexpected response: expected none, actual quo %h rem %h dz %b",
                     $time, got.quo, got.rem, got.dz);
            return;
         end
         want = expected_q.pop_front();
         compare_field("quotient_w0", want.quo[0*WORD_W +: WORD_W],
                       got.quo[0*WORD_W +: WORD_W]);
         compare_field("quotient_w1", want.quo[1*WORD_W +: WORD_W],
                       got.quo[1*WORD_W +: WORD_W]);
         compare_field("quotient_w2", want.quo[2*WORD_W +: WORD_W],
                       got.quo[2*WORD_W +: WORD_W]);
         compare_field("quotient_w3", want.quo[3*WORD_W +: WORD_W],
                       got.quo[3*WORD_W +: WORD_W]);
         compare_field("remainder_lo", want.rem[WORD_W-1:0], got.rem[WORD_W-1:0]);
         compare_field("remainder_hi", want.rem[DEN_W-1:WORD_W],
                       got.rem[DEN_W-1:WORD_W]);
         compare_field("divide_by_zero", WORD_W'(want.dz), WORD_W'(got.dz));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   udiv_req_if req_ch ();
   udiv_rsp_if rsp_ch ();

   udiv_256_by_128 u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   division_scoreboard sb = new();

   bit          sender_idle   = 1'b1;
   bit          receiver_idle = 1'b1;
   int unsigned rsp_hold_cycles = 0;
   int unsigned cycle_count     = 0;

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, sb.pending());
         $display("FAIL");
         $finish;
      end
   end

   // transaction monitors on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_division({req_ch.numerator_w3, req_ch.numerator_w2,
                              req_ch.numerator_w1, req_ch.numerator_w0},
                             {req_ch.denominator_hi, req_ch.denominator_lo});
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result('{dz:  rsp_ch.divide_by_zero,
                              quo: {rsp_ch.quotient_w3, rsp_ch.quotient_w2,
                                    rsp_ch.quotient_w1, rsp_ch.quotient_w0},
                              rem: {rsp_ch.remainder_hi, rsp_ch.remainder_lo}});
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int unsigned gap;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         gap = receiver_idle ? $urandom_range(0, MAX_GAP) : 0;
         if (rsp_hold_cycles > 0) begin
            gap             = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   task automatic drive_division(input division_type d);
      int unsigned gap;
      gap = sender_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.numerator_w0   <= d.num[0*WORD_W +: WORD_W];
      req_ch.numerator_w1   <= d.num[1*WORD_W +: WORD_W];
      req_ch.numerator_w2   <= d.num[2*WORD_W +: WORD_W];
      req_ch.numerator_w3   <= d.num[3*WORD_W +: WORD_W];
      req_ch.denominator_lo <= d.den[WORD_W-1:0];
      req_ch.denominator_hi <= d.den[DEN_W-1:WORD_W];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // lower valid and hold off until every expected response is back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic [WORD_W-1:0] pattern_word();
      logic [WORD_W-1:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return WORD_MAX;
         2:       return WORD_W'(1);
         3:       return WORD_MSB;
         4:       return w >> $urandom_range(1, WORD_W - 1);
         default: return w;
      endcase
   endfunction

   function automatic division_type random_division();
      division_type      d;
      logic [DEN_W-1:0]  wide;
      int unsigned       kind;
      kind = $urandom_range(0, 99);
      for (int w = 0; w < 4; w++)
         d.num[w*WORD_W +: WORD_W] = pattern_word();
      d.den = {pattern_word(), pattern_word()};
      if (kind < 3) begin
         d.den = '0;
      end else if (kind < 25) begin
         // narrow denominator: long quotients
         d.den = {{WORD_W{1'b0}}, {$urandom, $urandom} >> $urandom_range(0, WORD_W - 1)};
         d.den[0] = d.den[0] | (d.den == '0);
      end else if (kind < 45) begin
         // top bit set: doubled remainder overflows 128 bits
         d.den[DEN_W-1] = 1'b1;
      end else if (kind < 60) begin
         // numerator below the denominator
         if (d.den == '0)
            d.den = DEN_MAX;
         wide  = {$urandom, $urandom, $urandom, $urandom};
         d.num = NUM_W'(wide % d.den);
      end else if (d.den == '0) begin
         d.den = {$urandom, $urandom, $urandom, $urandom};
      end
      return d;
   endfunction

   function automatic division_type make_div(logic [NUM_W-1:0] num,
                                             logic [DEN_W-1:0] den);
      division_type d;
      d.num = num;
      d.den = den;
      return d;
   endfunction

   initial begin
      division_type directed_q[$];

      req_ch.valid          <= 1'b0;
      req_ch.numerator_w0   <= '0;
      req_ch.numerator_w1   <= '0;
      req_ch.numerator_w2   <= '0;
      req_ch.numerator_w3   <= '0;
      req_ch.denominator_lo <= '0;
      req_ch.denominator_hi <= '0;
      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;

      // zero denominator
      directed_q.push_back(make_div('0, '0));
      directed_q.push_back(make_div(NUM_MAX, '0));
      // field extremes
      directed_q.push_back(make_div('0, DEN_W'(1)));
      directed_q.push_back(make_div(NUM_MAX, DEN_W'(1)));
      directed_q.push_back(make_div(NUM_MAX, DEN_MAX));
      directed_q.push_back(make_div('0, DEN_MAX));
      directed_q.push_back(make_div(NUM_MAX, {1'b1, {(DEN_W-1){1'b0}}}));
      // remainder carry beyond 128 bits
      directed_q.push_back(make_div(NUM_MAX, DEN_MAX - 1));
      directed_q.push_back(make_div({$urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom},
                                    {1'b1, {(DEN_W-2){1'b0}}, 1'b1}));
      // numerator below denominator
      directed_q.push_back(make_div(NUM_W'(5), DEN_W'(7)));
      directed_q.push_back(make_div(NUM_W'(DEN_MAX - 1), DEN_MAX));
      directed_q.push_back(make_div(NUM_W'(1), DEN_MAX));
      // exact and word-boundary cases
      directed_q.push_back(make_div(NUM_W'(128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210),
                                    128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210));
      directed_q.push_back(make_div({1'b1, {(NUM_W-1){1'b0}}}, DEN_W'(3)));
      directed_q.push_back(make_div(NUM_MAX, {{(WORD_W-1){1'b0}}, 1'b1, {WORD_W{1'b0}}}));
      directed_q.push_back(make_div(NUM_MAX, {{WORD_W{1'b0}}, WORD_MAX}));
      directed_q.push_back(make_div({WORD_MSB, {(3*WORD_W){1'b0}}}, {WORD_MAX, {WORD_W{1'b0}}}));
      directed_q.push_back(make_div(NUM_W'(DEN_MAX), DEN_W'(2)));
      directed_q.push_back(make_div({DEN_MAX, {DEN_W{1'b0}}}, DEN_MAX));
      directed_q.push_back(make_div({4{64'haaaa_aaaa_aaaa_aaaa}},
                                    {{WORD_W{1'b0}}, 64'h5555_5555_5555_5555}));
      directed_q.push_back(make_div({4{64'h5555_5555_5555_5555}},
                                    {2{64'haaaa_aaaa_aaaa_aaaa}}));

      foreach (directed_q[i])
         drive_division(directed_q[i]);
      wait_drained();

      repeat (300) drive_division(random_division());

      // back-to-back stretch on both sides
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      repeat (300) drive_division(random_division());
      wait_drained();

      // response side holds off while requests keep coming: pipeline fills
      receiver_idle   = 1'b1;
      rsp_hold_cycles = LONG_HOLD;
      repeat (400) drive_division(random_division());
      wait_drained();

      sender_idle = 1'b1;
      repeat (300) drive_division(random_division());
      wait_drained();

      repeat (SETTLE) @(posedge clock);
      if (sb.pending() != 0)
         $display("%0t %0d expected results never arrived", $time, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
